[sv/parallel_port_interface_adapter_macros.svh]
// ----------------------------------------------------------------------------
// Parallel port interface adapter: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off during
// reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_PORT_INTERFACE_ADAPTER_MACROS_SVH
`define PARALLEL_PORT_INTERFACE_ADAPTER_MACROS_SVH

// Same-cycle implication.
`define PPIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PPIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/ppia_pkg.sv]
// ----------------------------------------------------------------------------
// Parallel port interface adapter package
// Command codes, control register bit positions, item and side status types.
// ----------------------------------------------------------------------------
`default_nettype none

package ppia_pkg;

    // Command codes carried in the slave tuser field.
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_PIN   = 3'd2;
    localparam logic [2:0] CMD_C1    = 3'd3;
    localparam logic [2:0] CMD_C2    = 3'd4;

    // Control register bit positions.
    localparam int CR_C1_EN    = 0;
    localparam int CR_C1_RISE  = 1;
    localparam int CR_PORT_SEL = 2;
    localparam int CR_C2_EN    = 3;
    localparam int CR_C2_RISE  = 4;
    localparam int CR_C2_OUT   = 5;
    localparam int CR_IRQ2     = 6;
    localparam int CR_IRQ1     = 7;

    localparam logic [7:0] CR_WRITABLE = 8'h3f;
    localparam logic [7:0] CR_FLAGS    = 8'hc0;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // One input item as held in the input register.
    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] reg_addr;
        logic [7:0] data_in;
        logic       pin_side;
        logic [7:0] pin_mask;
    } t_item;

    // Status of one side for the item being executed.
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] out_old;
        logic [7:0] out_new;
        logic       c2_old;
        logic       c2_new;
        logic       irq_now;
        logic       irq_next;
    } t_side_res;

    // Level on the C2 line as seen from the port: driven when C2 is an output.
    function automatic logic c2_pin_level(input logic [7:0] ctrl);
        c2_pin_level = ctrl[CR_C2_OUT] ? ctrl[CR_C2_EN] : 1'b1;
    endfunction

    // Interrupt request of one side from its control register.
    function automatic logic side_irq(input logic [7:0] ctrl);
        side_irq = (ctrl[CR_C1_EN] & ctrl[CR_IRQ1]) | (ctrl[CR_C2_EN] & ctrl[CR_IRQ2]);
    endfunction

endpackage

`default_nettype wire

[sv/parallel_port_interface_adapter.sv]
// ----------------------------------------------------------------------------
// Parallel port interface adapter
// Two-sided 8-bit parallel port with control, direction and port registers,
// driven by a command stream; one status transfer per command.
// ----------------------------------------------------------------------------
// Path: an accepted command is held in the input register, then its result in the result register.
// Throughput: one command per cycle while the master side does not stall; the input
// register feeds the side registers and the result register in a single pass.
// Reset: synchronous, active low; clears all side registers, line levels and
// both pipeline valid bits.
`default_nettype none

`include "parallel_port_interface_adapter_macros.svh"

module parallel_port_interface_adapter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // reg_addr[1:0], data_in[9:2], pin_side[10], pin_mask[18:11], zero fill
    input  wire logic [ppia_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // command[2:0]
    input  wire logic [ppia_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // read_data[7:0], irq_out[8], output_changed[9], output_side[10],
    // drive_value[18:11], c2_changed[19], c2_level[20], zero fill
    output logic [ppia_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    logic                           r_in_valid;
    ppia_pkg::t_item                r_in;
    logic                           r_out_valid;
    logic [ppia_pkg::M_TDATA_W-1:0] r_out_data;
    logic [ppia_pkg::M_TDATA_W-1:0] n_out_data;
    logic                           w_advance;
    logic                           w_exec;
    logic                           w_is_write;
    ppia_pkg::t_side_res            w_res_a;
    ppia_pkg::t_side_res            w_res_b;
    ppia_pkg::t_side_res            w_res_w;

    // Stage control: move when the result register is free or being taken.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_exec        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd      <= s_axis_tuser[2:0];
            r_in.reg_addr <= s_axis_tdata[1:0];
            r_in.data_in  <= s_axis_tdata[9:2];
            r_in.pin_side <= s_axis_tdata[10];
            r_in.pin_mask <= s_axis_tdata[18:11];
        end
    end

    // Port sides A and B.
    ppia_side u_side_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_exec),
        .i_bus_sel (!r_in.reg_addr[1]),
        .i_pin_sel (!r_in.pin_side),
        .i_item    (r_in),
        .o_res     (w_res_a)
    );

    ppia_side u_side_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_exec),
        .i_bus_sel (r_in.reg_addr[1]),
        .i_pin_sel (r_in.pin_side),
        .i_item    (r_in),
        .o_res     (w_res_b)
    );

    // Result assembly; write fields report only on a bus write.
    assign w_is_write = (r_in.cmd == ppia_pkg::CMD_WRITE);
    assign w_res_w    = r_in.reg_addr[1] ? w_res_b : w_res_a;

    always_comb begin
        n_out_data = {
            3'b000,
            w_is_write & w_res_w.c2_new,
            w_is_write & (w_res_w.c2_new != w_res_w.c2_old),
            w_is_write ? w_res_w.out_new : 8'h00,
            w_is_write & r_in.reg_addr[1],
            w_is_write & (w_res_w.out_new != w_res_w.out_old),
            w_res_a.irq_next | w_res_b.irq_next,
            w_res_a.read_data | w_res_b.read_data
        };
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks on the pipeline and result fields.
    `PPIA_ASSERT_NEXT(a_irq_tracks_state, w_exec,
        r_out_data[8] == (w_res_a.irq_now | w_res_b.irq_now),
        "Reported interrupt does not match the updated control registers")
    `PPIA_ASSERT_NOW(a_read_write_exclusive, r_out_valid && (r_out_data[19:9] != 11'd0),
        r_out_data[7:0] == 8'h00,
        "Read data and write status reported in the same transfer")
    `PPIA_ASSERT_NEXT(a_in_held_on_stall, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in),
        "Input register changed while the result side was stalled")

endmodule

`default_nettype wire

[sv/ppia_side.sv]
// ----------------------------------------------------------------------------
// Parallel port interface adapter: one port side
// Holds the control, direction and port registers and the last C1 and C2
// levels of one side, and applies one item to them when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module ppia_side (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,       // item executes this cycle
    input  wire logic               i_bus_sel,  // bus access addresses this side
    input  wire logic               i_pin_sel,  // pin or line event targets this side
    input  wire ppia_pkg::t_item    i_item,
    output ppia_pkg::t_side_res     o_res
);

    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_dir,  n_dir;
    logic [7:0] r_port, n_port;
    logic       r_c1,   n_c1;
    logic       r_c2,   n_c2;
    logic [7:0] w_rd;
    logic [7:0] w_mask;
    logic       w_level;
    logic       w_is_ctrl;

    assign w_level   = |i_item.data_in;
    assign w_is_ctrl = i_item.reg_addr[0];
    assign w_mask    = i_item.pin_mask & ~r_dir;

    // Next state and read data for the current item.
    always_comb begin
        n_ctrl = r_ctrl;
        n_dir  = r_dir;
        n_port = r_port;
        n_c1   = r_c1;
        n_c2   = r_c2;
        w_rd   = 8'h00;
        case (i_item.cmd)
            ppia_pkg::CMD_READ: begin
                if (i_bus_sel) begin
                    if (w_is_ctrl) begin
                        w_rd = r_ctrl;
                    end else if (r_ctrl[ppia_pkg::CR_PORT_SEL]) begin
                        // A port read clears both flags.
                        w_rd   = r_port;
                        n_ctrl = r_ctrl & ppia_pkg::CR_WRITABLE;
                    end else begin
                        w_rd = r_dir;
                    end
                end
            end
            ppia_pkg::CMD_WRITE: begin
                if (i_bus_sel) begin
                    if (w_is_ctrl) begin
                        n_ctrl = (r_ctrl & ppia_pkg::CR_FLAGS) |
                                 (i_item.data_in & ppia_pkg::CR_WRITABLE);
                    end else if (r_ctrl[ppia_pkg::CR_PORT_SEL]) begin
                        // Only output bits take the written value.
                        n_port = (r_port & ~r_dir) | (i_item.data_in & r_dir);
                    end else begin
                        n_dir = i_item.data_in;
                    end
                end
            end
            ppia_pkg::CMD_PIN: begin
                if (i_pin_sel) begin
                    n_port = (r_port & ~w_mask) | (i_item.data_in & w_mask);
                end
            end
            ppia_pkg::CMD_C1: begin
                if (i_pin_sel) begin
                    if (r_ctrl[ppia_pkg::CR_C1_RISE] ? (!r_c1 && w_level)
                                                     : (r_c1 && !w_level)) begin
                        n_ctrl[ppia_pkg::CR_IRQ1] = 1'b1;
                    end
                    n_c1 = w_level;
                end
            end
            ppia_pkg::CMD_C2: begin
                // An output C2 line ignores line events.
                if (i_pin_sel && !r_ctrl[ppia_pkg::CR_C2_OUT]) begin
                    if (r_ctrl[ppia_pkg::CR_C2_RISE] ? (!r_c2 && w_level)
                                                     : (r_c2 && !w_level)) begin
                        n_ctrl[ppia_pkg::CR_IRQ2] = 1'b1;
                    end
                    n_c2 = w_level;
                end
            end
            default: begin
            end
        endcase
    end

    // Side status seen by the result logic.
    always_comb begin
        o_res.read_data = w_rd;
        o_res.out_old   = r_dir & r_port;
        o_res.out_new   = n_dir & n_port;
        o_res.c2_old    = ppia_pkg::c2_pin_level(r_ctrl);
        o_res.c2_new    = ppia_pkg::c2_pin_level(n_ctrl);
        o_res.irq_now   = ppia_pkg::side_irq(r_ctrl);
        o_res.irq_next  = ppia_pkg::side_irq(n_ctrl);
    end

    // Side registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= 8'h00;
            r_dir  <= 8'h00;
            r_port <= 8'h00;
            r_c1   <= 1'b0;
            r_c2   <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
            r_dir  <= n_dir;
            r_port <= n_port;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
        end
    end

endmodule

`default_nettype wire
